[src/owm_pkg.sv]
`timescale 1ns / 1ps
// owm_pkg: shared types and constants for the 1-wire master slot engine
// no dependencies

package owm_pkg;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_RESET = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } act_type;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_NO_PRES  = 2'd1;
   localparam logic [1:0] ERR_SHORTED  = 2'd2;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] REG_RESET_LOW        = 3'd0;
   localparam logic [2:0] REG_PRESENCE_WAIT    = 3'd1;
   localparam logic [2:0] REG_SLOT_LOW         = 3'd2;
   localparam logic [2:0] REG_WRITE_SLOT       = 3'd3;
   localparam logic [2:0] REG_READ_SAMPLE      = 3'd4;
   localparam logic [2:0] REG_PRESENCE_TIMEOUT = 3'd5;
   localparam logic [2:0] REG_RELEASE_TIMEOUT  = 3'd6;

   localparam logic [9:0] RST_RESET_LOW        = 10'd480;
   localparam logic [9:0] RST_PRESENCE_WAIT    = 10'd30;
   localparam logic [3:0] RST_SLOT_LOW         = 4'd3;
   localparam logic [9:0] RST_WRITE_SLOT       = 10'd60;
   localparam logic [7:0] RST_READ_SAMPLE      = 8'd15;
   localparam logic [9:0] RST_PRESENCE_TIMEOUT = 10'hFF;
   localparam logic [9:0] RST_RELEASE_TIMEOUT  = 10'd510;

   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = 1;
   localparam int Q_CNT_BITS = 2;

   typedef struct packed {
      logic [9:0] reset_low;
      logic [9:0] presence_wait;
      logic [3:0] slot_low;
      logic [9:0] write_slot;
      logic [7:0] read_sample;
      logic [9:0] presence_timeout;
      logic [9:0] release_timeout;
   } cfg_type;

   typedef struct packed {
      act_type action;
      logic    write_value;
      logic    line_level;
   } cmd_type;

endpackage

[src/owm_req_if.sv]
`timescale 1ns / 1ps
// owm_req_if: tick request channel, valid/ready with tick payload
// depends on nothing

interface owm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       write_value;
   logic       line_level;

   modport source (output valid, output action, output write_value, output line_level,
                   input ready);
   modport sink   (input valid, input action, input write_value, input line_level,
                   output ready);
endinterface

[src/owm_rsp_if.sv]
`timescale 1ns / 1ps
// owm_rsp_if: per-tick result channel, valid/ready with bus and status payload
// depends on nothing

interface owm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       read_value;
   logic       presence_ok;
   logic [1:0] error_code;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output read_value, output presence_ok, output error_code,
                   input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input read_value, input presence_ok, input error_code,
                   output ready);
endinterface

[src/owm_front.sv]
`timescale 1ns / 1ps
// owm_front: accepts tick transactions, classifies the action, registers the command
// depends on owm_pkg and owm_req_if

module owm_front (
   input  logic              clock,
   input  logic              reset,
   owm_req_if.sink           req_if,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output owm_pkg::cmd_type  cmd
);

   logic             valid_ff, valid_in;
   owm_pkg::cmd_type cmd_ff, cmd_in;
   logic             take;

   assign req_if.ready = !valid_ff || cmd_ready;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (cmd_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in           = 1'b1;
         cmd_in.action      = owm_pkg::act_type'(req_if.action);
         cmd_in.write_value = req_if.write_value;
         cmd_in.line_level  = req_if.line_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

[src/owm_queue.sv]
`timescale 1ns / 1ps
// owm_queue: two-entry command queue between front and back
// depends on owm_pkg

module owm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  owm_pkg::cmd_type  in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output owm_pkg::cmd_type  out_cmd
);

   owm_pkg::cmd_type                    mem_ff [owm_pkg::Q_DEPTH];
   logic [owm_pkg::Q_PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [owm_pkg::Q_PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [owm_pkg::Q_CNT_BITS-1:0]      count_ff, count_in;
   logic                                push, pop;

   assign in_ready  = (count_ff != owm_pkg::Q_CNT_BITS'(owm_pkg::Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= owm_pkg::Q_CNT_BITS'(owm_pkg::Q_DEPTH))
      else $error("queue count beyond depth");

endmodule

[src/owm_back.sv]
`timescale 1ns / 1ps
// owm_back: slot timing engine, one queued tick per cycle unless the response stalls, registered result
// depends on owm_pkg and owm_rsp_if

module owm_back #(
   parameter int COUNT_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  owm_pkg::cfg_type  cfg,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  owm_pkg::cmd_type  cmd,
   owm_rsp_if.source         rsp_if
);

   localparam int CW = (COUNT_BITS > 10) ? COUNT_BITS : 10;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_PRES_FALL, PH_PRES_RISE,
      PH_W_LOW, PH_W_REST, PH_R_LOW, PH_R_WAIT, PH_R_RELEASE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  bit_ff, bit_in;
   logic                  sampled_ff, sampled_in;
   logic                  pres_ff, pres_in;
   logic [1:0]            status_ff, status_in;
   logic                  drive_in, done_in;

   logic                  rsp_valid_ff;
   logic                  rsp_drive_ff, rsp_busy_ff, rsp_done_ff;
   logic                  take;

   function automatic logic reached(input logic [COUNT_BITS-1:0] c, input logic [9:0] lim);
      return (CW'(c) >= CW'(lim)) || (c == CNT_MAX);
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_if.ready;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      logic consumed;
      phase_in   = phase_ff;
      count_in   = count_ff;
      bit_in     = bit_ff;
      sampled_in = sampled_ff;
      pres_in    = pres_ff;
      status_in  = status_ff;
      drive_in   = 1'b0;
      done_in    = 1'b0;
      consumed   = 1'b0;

      if (phase_ff == PH_IDLE) begin
         unique case (cmd.action)
            owm_pkg::ACT_RESET: begin
               phase_in = PH_RST_LOW;
               count_in = '0;
            end
            owm_pkg::ACT_WRITE: begin
               bit_in   = cmd.write_value;
               phase_in = PH_W_LOW;
               count_in = '0;
            end
            owm_pkg::ACT_READ: begin
               phase_in = PH_R_LOW;
               count_in = '0;
            end
            default: consumed = 1'b1;
         endcase
      end

      // zero-length phases chain within one tick, at most four steps
      for (int i = 0; i < 4; i++) begin
         if (!consumed) begin
            unique case (phase_in)
               PH_RST_LOW: begin
                  if (reached(count_in, cfg.reset_low)) begin
                     phase_in = PH_RST_WAIT;
                     count_in = '0;
                  end else begin
                     drive_in = 1'b1;
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                     consumed = 1'b1;
                  end
               end
               PH_RST_WAIT: begin
                  if (reached(count_in, cfg.presence_wait)) begin
                     phase_in = PH_PRES_FALL;
                     count_in = '0;
                  end else begin
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                     consumed = 1'b1;
                  end
               end
               PH_PRES_FALL: begin
                  if (reached(count_in, cfg.presence_timeout)) begin
                     status_in = owm_pkg::ERR_NO_PRES;
                     pres_in   = 1'b0;
                     phase_in  = PH_IDLE;
                     count_in  = '0;
                     done_in   = 1'b1;
                     consumed  = 1'b1;
                  end else if (!cmd.line_level) begin
                     phase_in = PH_PRES_RISE;
                     count_in = '0;
                  end else begin
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                     consumed = 1'b1;
                  end
               end
               PH_PRES_RISE: begin
                  if (reached(count_in, cfg.release_timeout)) begin
                     status_in = owm_pkg::ERR_SHORTED;
                     pres_in   = 1'b0;
                     phase_in  = PH_IDLE;
                     count_in  = '0;
                     done_in   = 1'b1;
                  end else if (cmd.line_level) begin
                     status_in = owm_pkg::ERR_OK;
                     pres_in   = 1'b1;
                     phase_in  = PH_IDLE;
                     count_in  = '0;
                     done_in   = 1'b1;
                  end else begin
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                  end
                  consumed = 1'b1;
               end
               PH_W_LOW: begin
                  if (reached(count_in, 10'(cfg.slot_low))) begin
                     phase_in = PH_W_REST;
                     count_in = '0;
                  end else begin
                     drive_in = 1'b1;
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                     consumed = 1'b1;
                  end
               end
               PH_W_REST: begin
                  if (reached(count_in, cfg.write_slot)) begin
                     phase_in = PH_IDLE;
                     count_in = '0;
                     done_in  = 1'b1;
                  end else begin
                     drive_in = !bit_in;
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                  end
                  consumed = 1'b1;
               end
               PH_R_LOW: begin
                  if (reached(count_in, 10'(cfg.slot_low))) begin
                     phase_in = PH_R_WAIT;
                     count_in = '0;
                  end else begin
                     drive_in = 1'b1;
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                     consumed = 1'b1;
                  end
               end
               PH_R_WAIT: begin
                  if (reached(count_in, 10'(cfg.read_sample))) begin
                     sampled_in = cmd.line_level;
                     phase_in   = PH_R_RELEASE;
                     count_in   = '0;
                  end else begin
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                     consumed = 1'b1;
                  end
               end
               PH_R_RELEASE: begin
                  if (reached(count_in, cfg.release_timeout)) begin
                     status_in = owm_pkg::ERR_SHORTED;
                     phase_in  = PH_IDLE;
                     count_in  = '0;
                     done_in   = 1'b1;
                  end else if (cmd.line_level) begin
                     phase_in = PH_IDLE;
                     count_in = '0;
                     done_in  = 1'b1;
                  end else begin
                     if (count_in != CNT_MAX) count_in = count_in + 1'b1;
                  end
                  consumed = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
                  count_in = '0;
                  consumed = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         bit_ff       <= 1'b0;
         sampled_ff   <= 1'b0;
         pres_ff      <= 1'b0;
         status_ff    <= owm_pkg::ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            bit_ff     <= bit_in;
            sampled_ff <= sampled_in;
            pres_ff    <= pres_in;
            status_ff  <= status_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (take) begin
         rsp_drive_ff <= drive_in;
         rsp_busy_ff  <= (phase_in != PH_IDLE);
         rsp_done_ff  <= done_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.drive_low   = rsp_drive_ff;
   assign rsp_if.busy_res    = rsp_busy_ff;
   assign rsp_if.done_res    = rsp_done_ff;
   assign rsp_if.read_value  = sampled_ff;
   assign rsp_if.presence_ok = pres_ff;
   assign rsp_if.error_code  = status_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff)
      else $error("done reported while still busy");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (count_ff == '0))
      else $error("tick count not cleared in idle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      (status_ff == owm_pkg::ERR_OK) || (status_ff == owm_pkg::ERR_NO_PRES) ||
      (status_ff == owm_pkg::ERR_SHORTED))
      else $error("undefined error code");

   a_busy_matches_phase: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_busy_ff == (phase_ff != PH_IDLE)))
      else $error("busy flag out of step with phase");

endmodule

[src/onewire_master_slot_engine.sv]
`timescale 1ns / 1ps
// onewire_master_slot_engine: top level, csr registers and front/queue/back hookup
// depends on owm_pkg, owm_req_if, owm_rsp_if, owm_front, owm_queue, owm_back

// Bit-level 1-wire bus master. Each request transaction is one 1 us tick carrying the
// sampled line level and an optional command (reset/presence, write bit, read bit); each
// one gives exactly one response transaction with the drive level and status for that
// tick. Throughput is one transaction per clock unless the response stalls; the back
// engine resolves a whole tick, zero-length phase chains included, combinationally. A
// request passes front register, queue, back output register. The user must write timing
// registers through the csr port only while no tick is in flight; this is not enforced.

module onewire_master_slot_engine #(
   parameter int COUNT_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   owm_req_if.sink                             req_if,
   owm_rsp_if.source                           rsp_if,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [owm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [owm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [owm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   owm_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       csr_index;
   logic             csr_write;

   logic             front_valid, front_ready;
   owm_pkg::cmd_type front_cmd;
   logic             queue_valid, queue_ready;
   owm_pkg::cmd_type queue_cmd;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            owm_pkg::REG_RESET_LOW:        cfg_in.reset_low        = csr_pwdata[9:0];
            owm_pkg::REG_PRESENCE_WAIT:    cfg_in.presence_wait    = csr_pwdata[9:0];
            owm_pkg::REG_SLOT_LOW:         cfg_in.slot_low         = csr_pwdata[3:0];
            owm_pkg::REG_WRITE_SLOT:       cfg_in.write_slot       = csr_pwdata[9:0];
            owm_pkg::REG_READ_SAMPLE:      cfg_in.read_sample      = csr_pwdata[7:0];
            owm_pkg::REG_PRESENCE_TIMEOUT: cfg_in.presence_timeout = csr_pwdata[9:0];
            owm_pkg::REG_RELEASE_TIMEOUT:  cfg_in.release_timeout  = csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         owm_pkg::REG_RESET_LOW:        csr_prdata = 32'(cfg_ff.reset_low);
         owm_pkg::REG_PRESENCE_WAIT:    csr_prdata = 32'(cfg_ff.presence_wait);
         owm_pkg::REG_SLOT_LOW:         csr_prdata = 32'(cfg_ff.slot_low);
         owm_pkg::REG_WRITE_SLOT:       csr_prdata = 32'(cfg_ff.write_slot);
         owm_pkg::REG_READ_SAMPLE:      csr_prdata = 32'(cfg_ff.read_sample);
         owm_pkg::REG_PRESENCE_TIMEOUT: csr_prdata = 32'(cfg_ff.presence_timeout);
         owm_pkg::REG_RELEASE_TIMEOUT:  csr_prdata = 32'(cfg_ff.release_timeout);
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low        <= owm_pkg::RST_RESET_LOW;
         cfg_ff.presence_wait    <= owm_pkg::RST_PRESENCE_WAIT;
         cfg_ff.slot_low         <= owm_pkg::RST_SLOT_LOW;
         cfg_ff.write_slot       <= owm_pkg::RST_WRITE_SLOT;
         cfg_ff.read_sample      <= owm_pkg::RST_READ_SAMPLE;
         cfg_ff.presence_timeout <= owm_pkg::RST_PRESENCE_TIMEOUT;
         cfg_ff.release_timeout  <= owm_pkg::RST_RELEASE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   owm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   owm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   owm_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_if    (rsp_if)
   );

endmodule
